/* hw/rtl/s98_command_stream_parser_macros.svh */
// ----------------------------------------------------------------------------
// s98 command stream parser: assertion macros
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef S98_COMMAND_STREAM_PARSER_MACROS_SVH
`define S98_COMMAND_STREAM_PARSER_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define S98_ASSERT_ALWAYS(label, clock, resetn, cond) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond)) \
        else $error("s98 parser: check failed");

// Consequent must hold in the same cycle as the antecedent.
`define S98_ASSERT_IMPL(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("s98 parser: implication failed");

// Consequent must hold in the cycle after the antecedent.
`define S98_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("s98 parser: next-cycle check failed");

`endif

/* hw/rtl/s98csp_pkg.sv */
// ----------------------------------------------------------------------------
// s98csp_pkg
// Types, widths and codes shared by the command stream parser and its checker.
// ----------------------------------------------------------------------------
package s98csp_pkg;

    // Configuration register widths and reset values
    localparam int CLK_W = 25;
    localparam int NUM_W = 16;
    localparam int DEN_W = 16;
    localparam logic [CLK_W-1:0] CLK_RESET = 25'd7987200;
    localparam logic [NUM_W-1:0] NUM_RESET = 16'd10;
    localparam logic [DEN_W-1:0] DEN_RESET = 16'd1000;

    // Command stream format
    localparam int MAX_COUNT_BYTES = 4;
    localparam int GROUP_BITS      = 7;
    localparam int TICK_ACC_W      = 28;
    localparam int TICKS_W         = TICK_ACC_W + 1;
    localparam int GRP_W           = $clog2(MAX_COUNT_BYTES + 1);
    localparam int SHIFT_W         = $clog2(GROUP_BITS * MAX_COUNT_BYTES);

    localparam logic [7:0] OP_BANK0    = 8'h00;
    localparam logic [7:0] OP_BANK1    = 8'h01;
    localparam logic [7:0] OP_WAIT_VAR = 8'hfe;
    localparam logic [7:0] OP_WAIT_ONE = 8'hff;
    localparam int         CONT_BIT    = 7;

    // Sample conversion datapath
    localparam int FRACTION_BITS = 16;
    localparam int WAIT_W        = 32;
    localparam int DIV_SCALE     = 144;
    localparam int SCALE_W       = 8;
    localparam int DIV_W         = DEN_W + SCALE_W;
    localparam int PROD_W        = CLK_W + NUM_W + TICKS_W;
    localparam int QUO_W         = WAIT_W + FRACTION_BITS;
    localparam int DIV_STEPS     = PROD_W + FRACTION_BITS;
    localparam int STEP_W        = $clog2(DIV_STEPS + 1);

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_CLOCK = 2'd0;
    localparam logic [1:0] REG_NUMER = 2'd1;
    localparam logic [1:0] REG_DENOM = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_WAIT  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } cmd_in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [8:0]        reg_addr;
        logic [7:0]        reg_data;
        logic [WAIT_W-1:0] wait_samples;
    } cmd_out_t;

endpackage

/* hw/rtl/s98_command_stream_parser.sv */
// ----------------------------------------------------------------------------
// s98_command_stream_parser
// Parses sound-log command bytes into register writes, sample waits and
// stream errors.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall / in_data) carries one command byte per
//   request, with end_of_data flagging the last byte of the log. The output
//   channel (out_valid / out_stall / out_data) carries at most one result per
//   byte: a 9-bit register write, a wait in whole samples, or an error.
//   Register writes and errors appear in the cycle after the byte is taken.
//   A wait runs through a bit-serial datapath: 29 shift-add steps of
//   ticks * clock, 16 steps of * numerator, then 86 restoring division steps
//   by 144 * denominator, and a write-back step into the output register.
//   No byte is taken while the conversion runs. Bytes that produce no
//   result do not hold up the input.
//   A finished result sits in an output register; while the receiver stalls
//   it is held and no further byte is taken.
//   After the first error the parser halts and answers every byte with an
//   error until reset. Reset (rst_n low, asynchronous) restores the register
//   defaults, clears the parse state, the kept sample fraction and the
//   output valid flag. The APB port writes the three conversion registers;
//   write them only while the parser is idle.
// ----------------------------------------------------------------------------
module s98_command_stream_parser
    import s98csp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // command byte requests
    input  logic              in_valid,
    output logic              in_stall,
    input  cmd_in_t           in_data,
    // result requests
    output logic              out_valid,
    input  logic              out_stall,
    output cmd_out_t          out_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Parse phases
    localparam logic [2:0] PH_OPCODE = 3'd0;
    localparam logic [2:0] PH_ADDR   = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_COUNT  = 3'd3;
    localparam logic [2:0] PH_ENDED  = 3'd4;

    // Conversion sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_T = 3'd1;
    localparam logic [2:0] ST_MUL_N = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CLK_W-1:0] clock_hz_reg;
    logic [NUM_W-1:0] numer_reg;
    logic [DEN_W-1:0] denom_reg;
    logic [1:0]       reg_idx;
    logic             cfg_write;

    assign reg_idx   = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLK_RESET;
            numer_reg    <= NUM_RESET;
            denom_reg    <= DEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_CLOCK: clock_hz_reg <= pwdata[CLK_W-1:0];
                REG_NUMER: numer_reg    <= pwdata[NUM_W-1:0];
                REG_DENOM: denom_reg    <= pwdata[DEN_W-1:0];
                default:   ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CLOCK: prdata = APB_DW'(clock_hz_reg);
            REG_NUMER: prdata = APB_DW'(numer_reg);
            REG_DENOM: prdata = APB_DW'(denom_reg);
            default:   prdata = '0;
        endcase
    end

    // Zero numerator or denominator falls back to the reset value
    logic [NUM_W-1:0] num_eff;
    logic [DEN_W-1:0] den_eff;
    logic [DIV_W-1:0] divisor_eff;

    assign num_eff     = (numer_reg == '0) ? NUM_RESET : numer_reg;
    assign den_eff     = (denom_reg == '0) ? DEN_RESET : denom_reg;
    assign divisor_eff = DIV_W'(den_eff) * DIV_W'(DIV_SCALE);

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic [2:0] seq_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       in_accept;

    // The output register is free when empty or being emptied this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (seq_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Byte parser
    // ------------------------------------------------------------------
    logic [2:0]            phase_reg,    phase_next;
    logic                  bank_reg,     bank_next;
    logic [7:0]            hold_reg,     hold_next;
    logic [TICK_ACC_W-1:0] tick_acc_reg, tick_acc_next;
    logic [GRP_W-1:0]      group_reg,    group_next;
    logic                  halted_reg,   halted_next;

    logic                  emit_err;
    logic                  emit_wr;
    logic                  start_wait;
    logic [TICKS_W-1:0]    wait_ticks;
    logic [SHIFT_W-1:0]    shift_amt;
    logic [TICK_ACC_W-1:0] digit_or;
    logic [2:0]            done_phase;
    logic [7:0]            byte_in;
    logic                  last_in;

    assign byte_in    = in_data.data_byte;
    assign last_in    = in_data.end_of_data;
    assign done_phase = last_in ? PH_ENDED : PH_OPCODE;
    assign shift_amt  = SHIFT_W'(group_reg) * SHIFT_W'(GROUP_BITS);
    // Count bytes arrive least significant group first
    assign digit_or   = tick_acc_reg | (TICK_ACC_W'(byte_in[GROUP_BITS-1:0]) << shift_amt);

    always_comb
    begin
        phase_next    = phase_reg;
        bank_next     = bank_reg;
        hold_next     = hold_reg;
        tick_acc_next = tick_acc_reg;
        group_next    = group_reg;
        halted_next   = halted_reg;
        emit_err      = 1'b0;
        emit_wr       = 1'b0;
        start_wait    = 1'b0;
        wait_ticks    = '0;

        if (in_accept)
        begin
            if (halted_reg)
            begin
                emit_err = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_OPCODE:
                    begin
                        priority if (byte_in == OP_BANK0 || byte_in == OP_BANK1)
                        begin
                            if (last_in)
                            begin
                                emit_err = 1'b1;
                            end
                            else
                            begin
                                bank_next  = byte_in[0];
                                phase_next = PH_ADDR;
                            end
                        end
                        else if (byte_in == OP_WAIT_ONE)
                        begin
                            phase_next = done_phase;
                            start_wait = 1'b1;
                            wait_ticks = TICKS_W'(1);
                        end
                        else if (byte_in == OP_WAIT_VAR)
                        begin
                            if (last_in)
                            begin
                                emit_err = 1'b1;
                            end
                            else
                            begin
                                tick_acc_next = '0;
                                group_next    = '0;
                                phase_next    = PH_COUNT;
                            end
                        end
                        else
                        begin
                            emit_err = 1'b1;
                        end
                    end
                    PH_ADDR:
                    begin
                        if (last_in)
                        begin
                            emit_err = 1'b1;
                        end
                        else
                        begin
                            hold_next  = byte_in;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        phase_next = done_phase;
                        emit_wr    = 1'b1;
                    end
                    PH_COUNT:
                    begin
                        priority if (int'(group_reg) >= MAX_COUNT_BYTES)
                        begin
                            emit_err = 1'b1;
                        end
                        else if (byte_in[CONT_BIT])
                        begin
                            if (last_in || (int'(group_reg) + 1 >= MAX_COUNT_BYTES))
                            begin
                                emit_err = 1'b1;
                            end
                            else
                            begin
                                tick_acc_next = digit_or;
                                group_next    = group_reg + GRP_W'(1);
                            end
                        end
                        else
                        begin
                            tick_acc_next = digit_or;
                            group_next    = '0;
                            phase_next    = done_phase;
                            start_wait    = 1'b1;
                            wait_ticks    = TICKS_W'(digit_or) + TICKS_W'(2);
                        end
                    end
                    default:
                    begin
                        // byte after the end of the log
                        emit_err = 1'b1;
                    end
                endcase
            end

            if (emit_err)
            begin
                halted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OPCODE;
            bank_reg     <= 1'b0;
            hold_reg     <= '0;
            tick_acc_reg <= '0;
            group_reg    <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            bank_reg     <= bank_next;
            hold_reg     <= hold_next;
            tick_acc_reg <= tick_acc_next;
            group_reg    <= group_next;
            halted_reg   <= halted_next;
        end
    end

    // ------------------------------------------------------------------
    // Bit-serial conversion: ticks * clock * numerator * 2^F / (144 * den)
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]    step_reg;
    logic [PROD_W-1:0]    mcand_reg;
    logic [TICKS_W-1:0]   mplier_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [DIV_W-1:0]     divisor_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic                 quo_ovf_reg;
    logic [FRACTION_BITS-1:0] frac_reg;

    logic [PROD_W-1:0]    acc_sum;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 q_bit;
    logic [DIV_W-1:0]     rem_next;
    logic [QUO_W:0]       total;
    logic                 saturate;
    logic [WAIT_W-1:0]    whole;
    logic                 done_load;

    assign acc_sum  = acc_reg + (mplier_reg[0] ? mcand_reg : '0);

    // Restoring division: bring down one dividend bit per cycle
    assign trial    = {rem_reg, acc_reg[PROD_W-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign q_bit    = !diff[DIV_W];
    assign rem_next = q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    // Add the kept fraction; whole samples saturate at the field width
    assign total    = {1'b0, quo_reg} + (QUO_W+1)'(frac_reg);
    assign saturate = quo_ovf_reg || total[QUO_W];
    assign whole    = saturate ? '1 : total[QUO_W-1:FRACTION_BITS];

    assign done_load = (seq_reg == ST_DONE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= ST_IDLE;
            step_reg <= '0;
        end
        else
        begin
            unique case (seq_reg)
                ST_IDLE:
                begin
                    if (start_wait)
                    begin
                        seq_reg  <= ST_MUL_T;
                        step_reg <= STEP_W'(TICKS_W - 1);
                    end
                end
                ST_MUL_T:
                begin
                    if (step_reg == '0)
                    begin
                        seq_reg  <= ST_MUL_N;
                        step_reg <= STEP_W'(NUM_W - 1);
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                ST_MUL_N:
                begin
                    if (step_reg == '0)
                    begin
                        seq_reg  <= ST_DIV;
                        step_reg <= STEP_W'(DIV_STEPS - 1);
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        seq_reg <= ST_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                ST_DONE:
                begin
                    // hold the result until the output register frees
                    if (out_free)
                    begin
                        seq_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    seq_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (seq_reg)
            ST_IDLE:
            begin
                if (start_wait)
                begin
                    mcand_reg   <= PROD_W'(clock_hz_reg);
                    mplier_reg  <= wait_ticks;
                    acc_reg     <= '0;
                    divisor_reg <= divisor_eff;
                end
            end
            ST_MUL_T:
            begin
                if (step_reg == '0)
                begin
                    // product of ticks and clock becomes the next multiplicand
                    mcand_reg  <= acc_sum;
                    acc_reg    <= '0;
                    mplier_reg <= TICKS_W'(num_eff);
                end
                else
                begin
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    acc_reg    <= acc_sum;
                end
            end
            ST_MUL_N:
            begin
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                acc_reg    <= acc_sum;
                if (step_reg == '0)
                begin
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    quo_ovf_reg <= 1'b0;
                end
            end
            ST_DIV:
            begin
                acc_reg     <= acc_reg << 1;
                rem_reg     <= rem_next;
                quo_reg     <= {quo_reg[QUO_W-2:0], q_bit};
                quo_ovf_reg <= quo_ovf_reg || quo_reg[QUO_W-1];
            end
            default:
            begin
                ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= '0;
        end
        else if (done_load)
        begin
            frac_reg <= total[FRACTION_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    cmd_out_t out_reg;
    cmd_out_t out_next;
    logic     out_load;

    always_comb
    begin
        out_next = '0;
        out_load = 1'b1;
        priority if (emit_err)
        begin
            out_next.kind = KIND_ERROR;
        end
        else if (emit_wr)
        begin
            out_next.kind     = KIND_WRITE;
            out_next.reg_addr = {bank_reg, hold_reg};
            out_next.reg_data = byte_in;
        end
        else if (done_load)
        begin
            out_next.kind         = KIND_WAIT;
            out_next.wait_samples = whole;
        end
        else
        begin
            out_load = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hw/rtl/s98csp_checker.sv */
// ----------------------------------------------------------------------------
// s98csp_checker
// Port-level checks on the command stream parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "s98_command_stream_parser_macros.svh"

module s98csp_checker
    import s98csp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input cmd_out_t          out_data
);

    // A stalled result holds
    `S98_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // Only register writes carry an address and data
    `S98_ASSERT_IMPL(a_write_fields, clk, rst_n, out_valid && out_data.kind != KIND_WRITE, out_data.reg_addr == '0 && out_data.reg_data == '0)

    // Only waits carry a sample count
    `S98_ASSERT_IMPL(a_wait_field, clk, rst_n, out_valid && out_data.kind != KIND_WAIT, out_data.wait_samples == '0)

    // No byte is taken while a result is held back
    `S98_ASSERT_IMPL(a_no_take_when_full, clk, rst_n, in_valid && !in_stall, !(out_valid && out_stall))

endmodule

bind s98_command_stream_parser s98csp_checker u_s98csp_checker (.*);

/* bench/s98_command_stream_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s98_command_stream_parser_tb
// Feeds command-byte requests through the parser and checks every result
// request against a cycle-free model of the parse state and of the
// wait-to-sample conversion, including the fraction carried between waits.
// Covers both register banks, both wait opcodes, several conversion settings
// (saturating, tiny, zero-valued), back-pressure and one randomly chosen
// stream error at the close of the run.
// ----------------------------------------------------------------------------
module s98_command_stream_parser_tb;
    import s98csp_pkg::*;

    localparam logic [7:0] COUNT_MASK  = 8'h7f;
    localparam logic [1:0] REG_UNUSED  = 2'd3;   // index past the register list
    localparam int         PHASES      = 9;
    localparam int         PHASE_BYTES = 70;
    localparam int         HOLD_CYCLES = 600;
    localparam int         DRAIN_LIMIT = 4000;

    typedef enum logic [2:0] {
        AWAIT_OP,
        AWAIT_ADDR,
        AWAIT_DATA,
        AWAIT_COUNT,
        PAST_END
    } parse_phase_e;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parse state on every accepted command byte and
    // holds the results that the parser owes.
    // ------------------------------------------------------------------------
    class parse_scoreboard;
        logic [CLK_W-1:0]         clock_hz;
        logic [NUM_W-1:0]         numer;
        logic [DEN_W-1:0]         denom;
        parse_phase_e             phase;
        logic                     bank;
        logic [7:0]               held_addr;
        logic [TICK_ACC_W-1:0]    ticks;
        int unsigned              groups;
        logic [FRACTION_BITS-1:0] frac;
        bit                       halted;
        cmd_out_t                 expected_results[$];
        int unsigned              errors;

        function new();
            clock_hz  = CLK_RESET;
            numer     = NUM_RESET;
            denom     = DEN_RESET;
            phase     = AWAIT_OP;
            bank      = 1'b0;
            held_addr = '0;
            ticks     = '0;
            groups    = 0;
            frac      = '0;
            halted    = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_CLOCK: clock_hz = value[CLK_W-1:0];
                REG_NUMER: numer    = value[NUM_W-1:0];
                REG_DENOM: denom    = value[DEN_W-1:0];
                default:   ;
            endcase
        endfunction

        // Exact ticks * clock * numer * 2^F / (144 * denom), plus the kept
        // fraction; the fraction is updated, the integer part saturates.
        function logic [WAIT_W-1:0] wait_to_samples(logic [63:0] n_ticks);
            logic [63:0] num_eff, divisor, product, q_c, r_c, r_1;
            logic [63:0] whole_part, rem, frac_part, frac_sum;
            num_eff    = (numer == '0) ? 64'(NUM_RESET) : 64'(numer);
            divisor    = 64'(DIV_SCALE) * ((denom == '0) ? 64'(DEN_RESET) : 64'(denom));
            product    = 64'(clock_hz) * num_eff;
            q_c        = product / divisor;
            r_c        = product % divisor;
            r_1        = r_c * n_ticks;
            whole_part = q_c * n_ticks + r_1 / divisor;
            rem        = r_1 % divisor;
            frac_part  = (rem << FRACTION_BITS) / divisor;
            frac_sum   = frac_part + 64'(frac);
            whole_part = whole_part + (frac_sum >> FRACTION_BITS);
            frac       = frac_sum[FRACTION_BITS-1:0];
            return (whole_part > 64'hffff_ffff) ? '1 : whole_part[WAIT_W-1:0];
        endfunction

        function void queue_result(logic [1:0] kind, logic [8:0] addr, logic [7:0] data,
                                   logic [WAIT_W-1:0] samples);
            cmd_out_t r;
            r.kind         = kind;
            r.reg_addr     = addr;
            r.reg_data     = data;
            r.wait_samples = samples;
            expected_results.push_back(r);
        endfunction

        function void raise_error();
            halted = 1'b1;
            queue_result(KIND_ERROR, '0, '0, '0);
        endfunction

        // Note one accepted command byte.
        function void take_byte(cmd_in_t req);
            logic [7:0]   b;
            logic         last;
            parse_phase_e after_cmd;
            b         = req.data_byte;
            last      = req.end_of_data;
            after_cmd = last ? PAST_END : AWAIT_OP;
            if (halted) begin
                raise_error();
                return;
            end
            case (phase)
                AWAIT_OP: begin
                    if (b == OP_BANK0 || b == OP_BANK1) begin
                        if (last) raise_error();
                        else begin
                            bank  = b[0];
                            phase = AWAIT_ADDR;
                        end
                    end
                    else if (b == OP_WAIT_ONE) begin
                        phase = after_cmd;
                        queue_result(KIND_WAIT, '0, '0, wait_to_samples(64'd1));
                    end
                    else if (b == OP_WAIT_VAR) begin
                        if (last) raise_error();
                        else begin
                            ticks  = '0;
                            groups = 0;
                            phase  = AWAIT_COUNT;
                        end
                    end
                    else raise_error();
                end
                AWAIT_ADDR: begin
                    if (last) raise_error();
                    else begin
                        held_addr = b;
                        phase     = AWAIT_DATA;
                    end
                end
                AWAIT_DATA: begin
                    phase = after_cmd;
                    queue_result(KIND_WRITE, {bank, held_addr}, b, '0);
                end
                AWAIT_COUNT: begin
                    if (groups >= MAX_COUNT_BYTES) raise_error();
                    else begin
                        ticks = ticks | (TICK_ACC_W'(b & COUNT_MASK) << (GROUP_BITS * groups));
                        if (b[CONT_BIT]) begin
                            if (last || groups + 1 >= MAX_COUNT_BYTES) raise_error();
                            else groups++;
                        end
                        else begin
                            groups = 0;
                            phase  = after_cmd;
                            queue_result(KIND_WAIT, '0, '0, wait_to_samples(64'(ticks) + 64'd2));
                        end
                    end
                end
                default: raise_error();
            endcase
        endfunction

        function void check_result(cmd_out_t got);
            cmd_out_t want;
            if (expected_results.size() == 0) begin
                $display("[%0t] unexpected result: kind %0d addr %h data %h wait %0d",
                         $time, got.kind, got.reg_addr, got.reg_data, got.wait_samples);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind) begin
                $display("[%0t] kind: expected %0d, actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.reg_addr !== want.reg_addr) begin
                $display("[%0t] reg_addr: expected %h, actual %h",
                         $time, want.reg_addr, got.reg_addr);
                errors++;
            end
            if (got.reg_data !== want.reg_data) begin
                $display("[%0t] reg_data: expected %h, actual %h",
                         $time, want.reg_data, got.reg_data);
                errors++;
            end
            if (got.wait_samples !== want.wait_samples) begin
                $display("[%0t] wait_samples: expected %0d, actual %0d",
                         $time, want.wait_samples, got.wait_samples);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    cmd_in_t           in_data;
    logic              out_valid;
    logic              out_stall;
    cmd_out_t          out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    s98_command_stream_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    parse_scoreboard sb;

    // Sender burst bookkeeping and the long hold-off handshake between the
    // stimulus process and the receiver process (one writer each).
    int unsigned burst_left;
    int unsigned bytes_sent;
    bit          hold_request;
    bit          hold_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: well beyond the slowest correct run (every byte a wait,
    // worst sender gaps and heavy receiver stalls).
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drive helpers. Inputs move on the falling edge; handshakes are judged
    // on the rising edge, where the stall seen is the one from before it.
    // ------------------------------------------------------------------------
    task automatic apb_write(logic [1:0] idx, logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one command byte; keep it steady until the parser takes it.
    // Between bursts drop valid for a random gap, or run a long burst with
    // no gap at all.
    task automatic send_byte(logic [7:0] b, logic last);
        cmd_in_t     req;
        int unsigned gap;
        req.data_byte   = b;
        req.end_of_data = last;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(40, 120);
                gap        = 0;
            end
            else begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 9);
            end
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        sb.take_byte(req);
        burst_left--;
        bytes_sent++;
    endtask

    // One well-formed command with random content. With close set, its
    // final byte is flagged as the end of the log.
    task automatic send_random_command(logic close);
        int unsigned sel;
        int unsigned n;
        logic [7:0]  cnt;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            send_byte(sel[0] ? OP_BANK1 : OP_BANK0, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), close);
        end
        else if (sel < 6) begin
            send_byte(OP_WAIT_ONE, close);
        end
        else begin
            send_byte(OP_WAIT_VAR, 1'b0);
            n = $urandom_range(1, MAX_COUNT_BYTES);
            for (int i = 0; i < n; i++) begin
                cnt = 8'($urandom_range(0, 127));
                if (i < n - 1) cnt[CONT_BIT] = 1'b1;
                send_byte(cnt, (i == n - 1) ? close : 1'b0);
            end
        end
    endtask

    // Hold the sender until every owed result is out, then let the parser
    // settle before touching the registers.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall on segments of random character, plus one long
    // hold-off so the output register fills and the input backs up.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned seg_mode;
        int unsigned seg_len;
        out_stall  = 1'b0;
        hold_taken = 1'b0;
        forever begin
            seg_mode = $urandom_range(0, 3);
            seg_len  = $urandom_range(10, 80);
            repeat (seg_len) begin
                @(negedge clk);
                if (hold_request && !hold_taken) begin
                    hold_taken = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (seg_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Check each result request as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        // Opening run at reset settings: both banks with extreme address and
        // data bytes, the one-tick wait, and counted waits from the shortest
        // count to the full four-byte count.
        logic [7:0] opening [25] = '{
            OP_BANK0, 8'h00, 8'h00,
            OP_BANK1, 8'hff, 8'hff,
            OP_BANK0, 8'ha5, 8'h5a,
            OP_BANK1, 8'h3c, 8'hc3,
            OP_WAIT_ONE,
            OP_WAIT_VAR, 8'h00,
            OP_WAIT_VAR, 8'h7f,
            OP_WAIT_VAR, 8'h80, 8'h01,
            OP_WAIT_VAR, 8'hff, 8'hff, 8'hff, 8'h7f
        };
        int unsigned target;
        int unsigned scenario;
        int unsigned spins;
        logic [7:0]  op;

        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_request = 1'b0;
        burst_left   = 0;
        bytes_sent   = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[i]) send_byte(opening[i], 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            // Settings change only with the parser idle. Phase 0 keeps the
            // reset values; then saturating, tiny, zero numer/denom, zero
            // clock, and random settings with junk in the upper bits.
            if (p > 0) begin
                drain_results();
                case (p)
                    1: begin
                        apb_write(REG_CLOCK, 32'hffff_ffff);
                        apb_write(REG_NUMER, 32'hffff_ffff);
                        apb_write(REG_DENOM, 32'd1);
                        apb_write(REG_UNUSED, $urandom);
                    end
                    2: begin
                        apb_write(REG_CLOCK, 32'd1);
                        apb_write(REG_NUMER, 32'd1);
                        apb_write(REG_DENOM, 32'h0000_ffff);
                    end
                    3: begin
                        apb_write(REG_CLOCK, $urandom);
                        apb_write(REG_NUMER, 32'd0);
                        apb_write(REG_DENOM, 32'd0);
                    end
                    4: begin
                        apb_write(REG_CLOCK, 32'd0);
                        apb_write(REG_NUMER, $urandom);
                        apb_write(REG_DENOM, $urandom);
                        hold_request = 1'b1;
                    end
                    default: begin
                        apb_write(REG_CLOCK, $urandom);
                        apb_write(REG_NUMER, {16'($urandom_range(0, 65535)),
                                              16'($urandom_range(1, 65535))});
                        apb_write(REG_DENOM, {16'($urandom_range(0, 65535)),
                                              16'($urandom_range(1, 65535))});
                    end
                endcase
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_random_command(1'b0);
        end

        // Any error halts the parser until reset, and reset is applied only
        // once, so a single error path closes the run, picked at random:
        // unknown opcode, opcode cut off, address cut off, count cut off,
        // count too long, or a byte past the end of the log.
        scenario = $urandom_range(0, 5);
        case (scenario)
            0: send_byte(8'($urandom_range(2, 253)), 1'($urandom_range(0, 1)));
            1: begin
                op = ($urandom_range(0, 2) == 0) ? OP_WAIT_VAR
                   : (($urandom_range(0, 1) == 0) ? OP_BANK0 : OP_BANK1);
                send_byte(op, 1'b1);
            end
            2: begin
                send_byte(($urandom_range(0, 1) == 0) ? OP_BANK0 : OP_BANK1, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            3: begin
                send_byte(OP_WAIT_VAR, 1'b0);
                send_byte(8'($urandom_range(128, 255)), 1'b1);
            end
            4: begin
                send_byte(OP_WAIT_VAR, 1'b0);
                repeat (MAX_COUNT_BYTES) send_byte(8'($urandom_range(128, 255)), 1'b0);
            end
            default: begin
                send_random_command(1'b1);
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        endcase
        // Every further byte must answer with an error.
        repeat ($urandom_range(3, 12))
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        @(negedge clk);
        in_valid <= 1'b0;
        spins = 0;
        while (sb.expected_results.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge clk);
            spins++;
        end
        repeat (150) @(posedge clk);

        if (sb.expected_results.size() != 0)
            $display("[%0t] %0d expected results never arrived",
                     $time, sb.expected_results.size());
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
